// ===== sv/hexzr_pkg.sv =====
// Shared constants, types and helper functions of the zero-run hex encoder.
package hexzr_pkg;

  // Number of decimal digits needed to print a value.
  function automatic int dec_digits(longint unsigned v);
    int n;
    longint unsigned x;
    n = 0;
    x = v;
    while (x > 0) begin
      x = x / 10;
      n = n + 1;
    end
    if (n == 0) begin
      n = 1;
    end
    return n;
  endfunction

  localparam int BYTE_W = 8;
  localparam int CAP_W  = 16;
  localparam int RUN_W  = 16;
  localparam int LEN_W  = 16;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam int RUN_DIGITS = dec_digits(longint'((64'd1 << RUN_W) - 64'd1));
  localparam int BCD_W      = 4 * RUN_DIGITS;
  // Longest unit is a bracket group: two brackets and the digits.
  localparam int UNIT_W     = $clog2(RUN_DIGITS + 3);
  localparam int ND_W       = $clog2(RUN_DIGITS + 1);
  localparam int CNT_W      = $clog2(RUN_W + 1);

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;

  typedef struct packed {
    logic              done;
    logic [BCD_W-1:0]  bcd;
  } bcd_stat_t;

  function automatic logic [BYTE_W-1:0] nibble_char(logic [3:0] v);
    logic [BYTE_W-1:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = CH_A + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== sv/hexzr_bin2bcd.sv =====
// Iterative binary to BCD converter, one shift-and-adjust step per cycle.
module hexzr_bin2bcd import hexzr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RUN_W-1:0] value,
  output bcd_stat_t        stat
);

  logic [RUN_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // Each digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < RUN_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bin  <= value;
        bcd  <= '0;
        cnt  <= CNT_W'(RUN_W);
      end else if (busy) begin
        bcd <= {bcd_adj[BCD_W-2:0], bin[RUN_W-1]};
        bin <= {bin[RUN_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.bcd  = bcd;

endmodule

// ===== sv/hex_encoder_zero_run.sv =====
// Top level of the zero-run hex encoder: sequencer, counters and output register.
//
//  channel  direction  handshake            payload
//  in       receive    in_valid / in_stall   data_byte, last_byte
//  out      send       out_valid / out_stall out_char, out_last, fail, encoded_length
//  cfg      receive    cfg_we                cfg_wdata (output_capacity)
//
// A byte that only extends a zero run is just accepted; a hex pair byte is accepted, then passes a flush,
// pair set-up, capacity check and the beats of its two characters, and a lone zero ahead adds a check and beats.
// A bracket group adds a flush, the RUN_W (16) steps of the shared BCD converter and its done beat,
// then digit normalising, the check and the characters. The byte marked last adds the NUL beat.
// The block takes no new byte until the sequencer is idle; the last result of a byte may still wait
// in the output register meanwhile. rst is synchronous, clears the run, the length count and the fail flag,
// and sets the capacity to 65535. A stalled output beat holds the sequencer in place.
module hex_encoder_zero_run import hexzr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_char,
  output logic              out_last,
  output logic              fail,
  output logic [LEN_W-1:0]  encoded_length
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FLUSH = 4'd1;
  localparam logic [3:0] S_CONV  = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_PAIR  = 4'd6;
  localparam logic [3:0] S_END   = 4'd7;
  localparam logic [3:0] S_FAIL  = 4'd8;

  logic [3:0]        state;
  logic [CAP_W-1:0]  capacity;
  logic [RUN_W-1:0]  run;
  logic [LEN_W-1:0]  chars;
  logic              failed;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic              do_pair;
  logic              grp;
  logic [BYTE_W-1:0] pair_val;
  logic [UNIT_W-1:0] unit_len;
  logic [UNIT_W-1:0] idx;
  logic [ND_W-1:0]   nd;
  logic [BCD_W-1:0]  digits;

  logic              conv_start;
  bcd_stat_t         conv_stat;

  logic              out_free;
  logic              out_load;
  logic              end_fail;
  logic              in_acc;
  logic [LEN_W:0]    total;
  logic              unit_fits;
  logic [BYTE_W-1:0] emit_char;
  logic              unit_done;
  logic [3:0]        after_unit;

  hexzr_bin2bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (run),
    .stat  (conv_stat)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // The NUL needs one place of its own beyond the text.
  assign end_fail = ({1'b0, chars} + (LEN_W+1)'(1)) > (LEN_W+1)'(capacity);
  assign out_load = out_free && ((state == S_EMIT) || (state == S_FAIL) ||
                                 ((state == S_END) && !end_fail));

  assign conv_start = (state == S_FLUSH) && (run > RUN_W'(1));

  assign total     = {1'b0, chars} + (LEN_W+1)'(unit_len);
  assign unit_fits = (total < (LEN_W+1)'(capacity)) && (total <= {1'b0, LEN_MAX});
  assign unit_done = (idx == unit_len - UNIT_W'(1));

  // Where the sequence goes once the current unit is settled.
  always_comb begin
    if (do_pair) begin
      after_unit = S_PAIR;
    end else if (last_q) begin
      after_unit = S_END;
    end else begin
      after_unit = S_IDLE;
    end
  end

  always_comb begin
    if (grp) begin
      if (idx == '0) begin
        emit_char = CH_LBRACK;
      end else if (unit_done) begin
        emit_char = CH_RBRACK;
      end else begin
        emit_char = CH_ZERO + {4'd0, digits[BCD_W-1 -: 4]};
      end
    end else if (idx == '0) begin
      emit_char = nibble_char(pair_val[7:4]);
    end else begin
      emit_char = nibble_char(pair_val[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= {CAP_W{1'b1}};
      run       <= '0;
      chars     <= '0;
      failed    <= 1'b0;
      do_pair   <= 1'b0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            byte_q  <= data_byte;
            last_q  <= last_byte;
            do_pair <= 1'b0;
            if (failed) begin
              if (last_byte) begin
                run    <= '0;
                chars  <= '0;
                failed <= 1'b0;
              end
            end else if (data_byte == '0) begin
              run <= run + 1'b1;
              if (run == RUN_MAX - RUN_W'(1) || last_byte) begin
                state <= S_FLUSH;
              end
            end else begin
              do_pair <= 1'b1;
              state   <= S_FLUSH;
            end
          end
        end

        S_FLUSH: begin
          run <= '0;
          if (run == '0) begin
            state <= after_unit;
          end else if (run == RUN_W'(1)) begin
            // A lone zero is written as an ordinary pair.
            grp      <= 1'b0;
            pair_val <= '0;
            unit_len <= UNIT_W'(2);
            state    <= S_CHECK;
          end else begin
            state <= S_CONV;
          end
        end

        S_CONV: begin
          if (conv_stat.done) begin
            digits <= conv_stat.bcd;
            nd     <= ND_W'(RUN_DIGITS);
            state  <= S_NORM;
          end
        end

        S_NORM: begin
          // Leading zero digits are shifted out so the first digit sits at the top.
          if (digits[BCD_W-1 -: 4] == 4'd0) begin
            digits <= {digits[BCD_W-5:0], 4'd0};
            nd     <= nd - 1'b1;
          end else begin
            grp      <= 1'b1;
            unit_len <= UNIT_W'(nd) + UNIT_W'(2);
            state    <= S_CHECK;
          end
        end

        S_PAIR: begin
          do_pair  <= 1'b0;
          grp      <= 1'b0;
          pair_val <= byte_q;
          unit_len <= UNIT_W'(2);
          state    <= S_CHECK;
        end

        S_CHECK: begin
          idx <= '0;
          if (unit_fits) begin
            chars <= total[LEN_W-1:0];
            state <= S_EMIT;
          end else begin
            state <= S_FAIL;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_char       <= emit_char;
            out_last       <= 1'b0;
            fail           <= 1'b0;
            encoded_length <= '0;
            idx            <= idx + 1'b1;
            if (grp && idx != '0 && !unit_done) begin
              digits <= {digits[BCD_W-5:0], 4'd0};
            end
            if (unit_done) begin
              state <= after_unit;
            end
          end
        end

        S_END: begin
          if (end_fail) begin
            state <= S_FAIL;
          end else if (out_free) begin
            out_char       <= CH_NUL;
            out_last       <= 1'b1;
            fail           <= 1'b0;
            encoded_length <= chars;
            run            <= '0;
            chars          <= '0;
            failed         <= 1'b0;
            state          <= S_IDLE;
          end
        end

        S_FAIL: begin
          if (out_free) begin
            out_char       <= CH_NUL;
            out_last       <= 1'b1;
            fail           <= 1'b1;
            encoded_length <= chars;
            run            <= '0;
            do_pair        <= 1'b0;
            if (last_q) begin
              chars  <= '0;
              failed <= 1'b0;
            end else begin
              failed <= 1'b1;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench of the zero-run hex encoder: a predicting scoreboard, byte stimulus and text checks.
`timescale 1ns / 100ps

module tb import hexzr_pkg::*; ();

  typedef struct packed {
    logic [BYTE_W-1:0] char_code;
    logic              end_flag;
    logic              fail_flag;
    logic [LEN_W-1:0]  text_len;
  } text_beat_t;

  // Predicts the text of each buffer and holds the beats still owed by the block.
  class hex_text_scoreboard;
    text_beat_t        expected_q[$];
    logic [BYTE_W-1:0] unit_q[$];
    logic [CAP_W-1:0]  capacity;
    logic [RUN_W-1:0]  run_len;
    int unsigned       written;
    bit                discarding;
    int                errors;

    function new();
      capacity = '1;
      errors = 0;
      clear_buffer();
    endfunction

    function void clear_buffer();
      run_len = '0;
      written = 0;
      discarding = 1'b0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [BYTE_W-1:0] hex_digit(logic [3:0] v);
      if (v < 4'd10) begin
        return CH_ZERO + {4'd0, v};
      end
      return CH_A + {4'd0, v} - 8'd10;
    endfunction

    function void push_beat(logic [BYTE_W-1:0] c, logic e, logic f, logic [LEN_W-1:0] n);
      text_beat_t t;
      t.char_code = c;
      t.end_flag = e;
      t.fail_flag = f;
      t.text_len = n;
      expected_q.push_back(t);
    endfunction

    // A unit is written whole or not at all; one place is always kept for the NUL.
    function bit emit_unit();
      longint unsigned total;
      total = longint'(written) + unit_q.size();
      if (total + 1 > capacity || total > LEN_MAX) begin
        unit_q.delete();
        return 1'b0;
      end
      foreach (unit_q[i]) begin
        push_beat(unit_q[i], 1'b0, 1'b0, '0);
      end
      unit_q.delete();
      written = int'(total);
      return 1'b1;
    endfunction

    function bit emit_pair(logic [BYTE_W-1:0] b);
      unit_q.delete();
      unit_q.push_back(hex_digit(b[7:4]));
      unit_q.push_back(hex_digit(b[3:0]));
      return emit_unit();
    endfunction

    function bit flush_run();
      int unsigned       v;
      logic [BYTE_W-1:0] digs[$];
      v = run_len;
      run_len = '0;
      if (v == 0) begin
        return 1'b1;
      end
      if (v == 1) begin
        return emit_pair(8'h00);
      end
      while (v > 0) begin
        digs.push_front(CH_ZERO + 8'(v % 10));
        v = v / 10;
      end
      unit_q.delete();
      unit_q.push_back(CH_LBRACK);
      foreach (digs[i]) begin
        unit_q.push_back(digs[i]);
      end
      unit_q.push_back(CH_RBRACK);
      return emit_unit();
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic lst);
      bit ok;
      ok = 1'b1;
      if (discarding) begin
        if (lst) begin
          clear_buffer();
        end
        return;
      end
      if (b == 8'h00) begin
        run_len = run_len + 1'b1;
        if (run_len == RUN_MAX) begin
          ok = flush_run();
        end
      end else begin
        ok = flush_run();
        if (ok) begin
          ok = emit_pair(b);
        end
      end
      if (ok && lst) begin
        ok = flush_run();
        if (ok && written + 1 > capacity) begin
          ok = 1'b0;
        end
        if (ok) begin
          push_beat(CH_NUL, 1'b1, 1'b0, LEN_W'(written));
          clear_buffer();
          return;
        end
      end
      if (!ok) begin
        push_beat(CH_NUL, 1'b1, 1'b1, LEN_W'(written));
        if (lst) begin
          clear_buffer();
        end else begin
          run_len = '0;
          discarding = 1'b1;
        end
      end
    endfunction

    function void check_beat(logic [BYTE_W-1:0] c, logic e, logic f, logic [LEN_W-1:0] n);
      text_beat_t t;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected text beat char %h last %b fail %b length %0d",
                 $time, c, e, f, n);
        errors++;
        return;
      end
      t = expected_q.pop_front();
      if (c !== t.char_code) begin
        $display("%0t: out_char expected %h got %h", $time, t.char_code, c);
        errors++;
      end
      if (e !== t.end_flag) begin
        $display("%0t: out_last expected %b got %b", $time, t.end_flag, e);
        errors++;
      end
      if (f !== t.fail_flag) begin
        $display("%0t: fail expected %b got %b", $time, t.fail_flag, f);
        errors++;
      end
      if (n !== t.text_len) begin
        $display("%0t: encoded_length expected %0d got %0d", $time, t.text_len, n);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CAP_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_char;
  logic              out_last;
  logic              fail;
  logic [LEN_W-1:0]  encoded_length;

  hex_text_scoreboard sb = new();

  logic [BYTE_W-1:0] buf_q[$];
  bit                tx_busy = 1'b1;
  bit                hold_req = 1'b0;
  int                n_bytes = 0;
  int                n_beats = 0;

  hex_encoder_zero_run i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last       (out_last),
    .fail           (fail),
    .encoded_length (encoded_length)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    int gap;
    gap = tx_busy ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, lst);
    n_bytes++;
  endtask

  // Sends buf_q as one buffer, the final byte marked last.
  task automatic send_buffer();
    foreach (buf_q[i]) begin
      send_byte(buf_q[i], i == buf_q.size() - 1);
    end
  endtask

  // Some items give no result, so the block may still be busy when the queue empties.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(v);
  endtask

  task automatic random_phase(input logic [CAP_W-1:0] cap, input int n_items);
    int sent;
    int len;
    int r;
    int k;
    write_capacity(cap);
    sent = 0;
    while (sent < n_items) begin
      tx_busy = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      buf_q.delete();
      while (buf_q.size() < len) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          buf_q.push_back(8'h00);
        end else if (r < 40) begin
          buf_q.push_back(8'hFF);
        end else if (r < 44) begin
          buf_q.push_back(8'h01);
        end else if (r < 50) begin
          k = $urandom_range(2, 15);
          repeat (k) buf_q.push_back(8'h00);
        end else begin
          buf_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_buffer();
      sent += buf_q.size();
    end
  endtask

  // Text sink: checks every accepted beat and stalls at random, once for a long stretch.
  initial begin : text_sink
    int stall_left;
    int since_draw;
    bit rx_busy;
    bit took;
    stall_left = 0;
    since_draw = 0;
    rx_busy = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      took = 1'b0;
      if (!rst && out_valid && !out_stall) begin
        sb.check_beat(out_char, out_last, fail, encoded_length);
        n_beats++;
        took = 1'b1;
      end
      @(negedge clk);
      if (hold_req) begin
        stall_left = 400;
        hold_req = 1'b0;
      end else if (took) begin
        since_draw++;
        if (since_draw == 32) begin
          rx_busy = ($urandom_range(0, 3) != 0);
          since_draw = 0;
        end
        if (rx_busy) begin
          stall_left = $urandom_range(0, 9);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default capacity: hex pairs, a lone zero, short and two-digit runs, a run at the end.
    buf_q = '{8'hFF};
    send_buffer();
    buf_q = '{8'h00};
    send_buffer();
    buf_q = '{8'h00, 8'h00};
    send_buffer();
    buf_q = '{8'h01, 8'h00, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h80};
    send_buffer();
    buf_q = '{8'h7F, 8'h00, 8'h00};
    send_buffer();
    buf_q = '{8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_buffer();

    // Smallest capacity: every unit fails.
    write_capacity(16'd1);
    buf_q = '{8'h12};
    send_buffer();
    buf_q = '{8'h00, 8'h00};
    send_buffer();

    // Failure in mid-buffer; the rest is discarded up to the last byte.
    write_capacity(16'd5);
    buf_q = '{8'h11, 8'h22, 8'h33, 8'h44};
    send_buffer();
    buf_q = '{8'h9C};
    send_buffer();

    // A bracket group that exactly fits, then one that does not.
    write_capacity(16'd4);
    buf_q = '{8'h00, 8'h00, 8'h00};
    send_buffer();
    write_capacity(16'd3);
    buf_q = '{8'h00, 8'h00, 8'h77, 8'h88};
    send_buffer();

    random_phase(16'($urandom_range(1, 65535)), 30);
    // The sink holds off for a long stretch while bytes keep coming.
    write_capacity(16'hFFFF);
    hold_req = 1'b1;
    tx_busy = 1'b0;
    buf_q.delete();
    repeat (30) buf_q.push_back(8'($urandom_range(1, 255)));
    send_buffer();
    random_phase(16'hFFFF, 30);
    random_phase(16'($urandom_range(1, 24)), 30);
    random_phase(16'($urandom_range(8, 60)), 30);
    random_phase(16'($urandom_range(1, 65535)), 30);
    random_phase(16'($urandom_range(2, 12)), 30);

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d text beats never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Encoded %0d bytes into %0d text beats over capacities from 1 to 65535,", n_bytes,
             n_beats);
    $display("with failures, discarded tails, a long sink stall and zero runs of many lengths.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== hex_encoder_zero_run.f =====
sv/hexzr_pkg.sv
sv/hexzr_bin2bcd.sv
sv/hex_encoder_zero_run.sv
tb/tb.sv
